>>> hw/rtl/sgrad_pkg.sv
// Shared types and constants for the two-channel Sobel gradient block.
package sgrad_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SAMPLE_BITS = 16;
    localparam int OUT_BITS    = SAMPLE_BITS + 3;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int ROW_BITS    = HEIGHT_BITS + 1;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 3;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] u;
        logic signed [SAMPLE_BITS-1:0] v;
    } vec_t;

    // One window column, index 0 is the upper row.
    typedef vec_t [2:0] col_t;

    // Line store entry: previous row and the row before it at one column.
    typedef struct packed {
        vec_t newer;
        vec_t older;
    } line_pair_t;

    // Effective frame geometry and restart strobe from the register file.
    typedef struct packed {
        logic [WIDTH_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
        logic                   restart;
    } cfg_t;

    // Clamped 3x3 neighborhood of one pixel, ready for the gradient sums.
    typedef struct packed {
        logic last;
        col_t left;
        col_t mid;
        col_t right;
    } nbhd_t;

endpackage

>>> hw/rtl/sgrad_linebuf.sv
// Two-row line store: one wide memory, one read and one write per cycle, with bypass.
module sgrad_linebuf
    import sgrad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [COL_BITS-1:0] rd_addr,
    input  logic                wr_en,
    input  logic [COL_BITS-1:0] wr_addr,
    input  line_pair_t          wr_data,
    output line_pair_t          rd_data
);

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;
    line_pair_t byp_data_reg;
    logic       byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // Read during write to the same column returns the new entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

>>> hw/rtl/sgrad_window.sv
// Frame counters, 3x3 window and edge clamping; registers at most one neighborhood per beat.
module sgrad_window
    import sgrad_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic signed [SAMPLE_BITS-1:0] flow_u,
    input  logic signed [SAMPLE_BITS-1:0] flow_v,
    output logic                          nb_valid,
    output nbhd_t                         nb,
    input  logic                          nb_ready
);

    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    col_t                wcol0_reg, wcol0_next;
    col_t                wcol1_reg, wcol1_next;
    col_t                wcol2_reg, wcol2_next;
    logic                nb_valid_reg, nb_valid_next;
    nbhd_t               nb_reg, nb_next;

    logic                accept;
    logic                active;
    logic                in_frame;
    logic                emit_old;
    logic                emit_new;
    logic                last_px;
    logic                row_wrap;
    logic                top_ok;
    logic                bot_ok;
    logic                stage_ready;
    logic [ROW_BITS-1:0] h_ext;
    vec_t                cur;
    col_t                new_col;
    col_t                src_l, src_m, src_r;
    line_pair_t          rd_pair;
    line_pair_t          wr_pair;

    assign stage_ready = !nb_valid_reg || nb_ready;
    assign in_stall    = !stage_ready;
    assign accept      = in_valid && stage_ready;

    assign h_ext    = {1'b0, cfg.height};
    assign in_frame = row_reg < h_ext;
    // Drop flush beats inside the frame and samples after it.
    assign active   = accept && (in_frame != (opcode == OP_FLUSH));

    assign cur.u = (opcode == OP_FLUSH) ? '0 : flow_u;
    assign cur.v = (opcode == OP_FLUSH) ? '0 : flow_v;

    assign new_col[0] = rd_pair.older;
    assign new_col[1] = rd_pair.newer;
    assign new_col[2] = cur;

    assign wr_pair.newer = cur;
    assign wr_pair.older = rd_pair.newer;

    assign emit_old = (col_reg == '0) && (row_reg >= ROW_BITS'(2));
    assign emit_new = (col_reg != '0) && (row_reg != '0);
    assign last_px  = emit_old && (row_reg == h_ext + ROW_BITS'(1));
    assign row_wrap = ({1'b0, col_reg} + WIDTH_BITS'(1)) >= cfg.width;

    sgrad_linebuf u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (col_next),
        .wr_en   (active),
        .wr_addr (col_reg),
        .wr_data (wr_pair),
        .rd_data (rd_pair)
    );

    // Pick the source columns and the row clamping for the pixel being emitted.
    always_comb
    begin
        if (emit_old)
        begin
            // Last pixel of the previous row, taken from the window before the shift.
            src_l  = (cfg.width == WIDTH_BITS'(1)) ? wcol2_reg : wcol1_reg;
            src_m  = wcol2_reg;
            src_r  = wcol2_reg;
            top_ok = row_reg >= ROW_BITS'(3);
            bot_ok = row_reg <= h_ext;
        end
        else
        begin
            src_l  = (col_reg == COL_BITS'(1)) ? wcol2_reg : wcol1_reg;
            src_m  = wcol2_reg;
            src_r  = new_col;
            top_ok = row_reg >= ROW_BITS'(2);
            bot_ok = row_reg < h_ext;
        end
        nb_next.last     = last_px;
        nb_next.left[0]  = top_ok ? src_l[0] : src_l[1];
        nb_next.left[1]  = src_l[1];
        nb_next.left[2]  = bot_ok ? src_l[2] : src_l[1];
        nb_next.mid[0]   = top_ok ? src_m[0] : src_m[1];
        nb_next.mid[1]   = src_m[1];
        nb_next.mid[2]   = bot_ok ? src_m[2] : src_m[1];
        nb_next.right[0] = top_ok ? src_r[0] : src_r[1];
        nb_next.right[1] = src_r[1];
        nb_next.right[2] = bot_ok ? src_r[2] : src_r[1];
    end

    // Advance counters and window, or clear them on restart or after the last pixel.
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        wcol0_next = wcol0_reg;
        wcol1_next = wcol1_reg;
        wcol2_next = wcol2_reg;
        priority if (cfg.restart || (active && last_px))
        begin
            col_next   = '0;
            row_next   = '0;
            wcol0_next = '0;
            wcol1_next = '0;
            wcol2_next = '0;
        end
        else if (active)
        begin
            wcol0_next = wcol1_reg;
            wcol1_next = wcol2_reg;
            wcol2_next = new_col;
            if (row_wrap)
            begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    assign nb_valid_next = active && (emit_old || emit_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            wcol0_reg    <= '0;
            wcol1_reg    <= '0;
            wcol2_reg    <= '0;
            nb_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            wcol0_reg <= wcol0_next;
            wcol1_reg <= wcol1_next;
            wcol2_reg <= wcol2_next;
            if (stage_ready)
            begin
                nb_valid_reg <= nb_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready)
        begin
            nb_reg <= nb_next;
        end
    end

    assign nb_valid = nb_valid_reg;
    assign nb       = nb_reg;

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < cfg.width))
        else $error("column counter beyond row width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= h_ext + ROW_BITS'(1)))
        else $error("row counter beyond flush rows");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (active && last_px) |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not restart after last pixel");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_old && emit_new))
        else $error("two pixels emitted for one beat");

endmodule

>>> hw/rtl/sgrad_sobel.sv
// Sobel x and y sums for both components into the result register.
module sgrad_sobel
    import sgrad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       nb_valid,
    input  nbhd_t                      nb,
    output logic                       nb_ready,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] grad_ux,
    output logic signed [OUT_BITS-1:0] grad_uy,
    output logic signed [OUT_BITS-1:0] grad_vx,
    output logic signed [OUT_BITS-1:0] grad_vy,
    output logic                       frame_end
);

    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] ux_reg, ux_next;
    logic signed [OUT_BITS-1:0] uy_reg, uy_next;
    logic signed [OUT_BITS-1:0] vx_reg, vx_next;
    logic signed [OUT_BITS-1:0] vy_reg, vy_next;
    logic                       end_reg;

    function automatic logic signed [OUT_BITS-1:0] wsum(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic signed [SAMPLE_BITS-1:0] c
    );
        logic signed [OUT_BITS-1:0] ea, eb, ec;
        ea = OUT_BITS'(a);
        eb = OUT_BITS'(b);
        ec = OUT_BITS'(c);
        return ea + (eb <<< 1) + ec;
    endfunction

    assign nb_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        ux_next = wsum(nb.right[0].u, nb.right[1].u, nb.right[2].u)
                - wsum(nb.left[0].u, nb.left[1].u, nb.left[2].u);
        uy_next = wsum(nb.left[2].u, nb.mid[2].u, nb.right[2].u)
                - wsum(nb.left[0].u, nb.mid[0].u, nb.right[0].u);
        vx_next = wsum(nb.right[0].v, nb.right[1].v, nb.right[2].v)
                - wsum(nb.left[0].v, nb.left[1].v, nb.left[2].v);
        vy_next = wsum(nb.left[2].v, nb.mid[2].v, nb.right[2].v)
                - wsum(nb.left[0].v, nb.mid[0].v, nb.right[0].v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (nb_ready)
        begin
            out_valid_reg <= nb_valid;
        end
    end

    // Hold the result while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (nb_ready && nb_valid)
        begin
            ux_reg  <= ux_next;
            uy_reg  <= uy_next;
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            end_reg <= nb.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign grad_ux   = ux_reg;
    assign grad_uy   = uy_reg;
    assign grad_vx   = vx_reg;
    assign grad_vy   = vy_reg;
    assign frame_end = end_reg;

endmodule

>>> hw/rtl/sobel_gradient_two_channel.sv
// Top level: register file, window stage and gradient stage of the two-channel Sobel block.
//
// Input channel (in_valid/in_stall) carries one beat per pixel in raster order:
// opcode sample with flow_u/flow_v, or a flush beat. After the W*H samples of a
// frame the host sends W+1 flush beats; beats of the wrong kind are taken and dropped.
// Output channel (out_valid/out_stall) carries grad_ux/uy/vx/vy for one pixel per
// beat, frame_end marking the last pixel. The result for raster pixel p comes from
// the beat at position p+W+1; the first W+1 beats of a frame give no result.
// A taken beat's neighborhood is registered, and its sums then go into the result register.
// Throughput: one beat per cycle while in_stall is low; the line store does one read and one write per
// cycle, with its read address running one column ahead.
// Stall: out_stall holds the result register; a pending neighborhood then holds and
// in_stall rises, so no beat is lost.
// Reset: image_width 640, image_height 480, counters and window cleared; the line
// store is not cleared. A register write restarts the frame.
module sobel_gradient_two_channel
    import sgrad_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]          prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic signed [SAMPLE_BITS-1:0] flow_u,
    input  logic signed [SAMPLE_BITS-1:0] flow_v,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_BITS-1:0]    grad_ux,
    output logic signed [OUT_BITS-1:0]    grad_uy,
    output logic signed [OUT_BITS-1:0]    grad_vx,
    output logic signed [OUT_BITS-1:0]    grad_vy,
    output logic                          frame_end
);

    logic [WIDTH_BITS-1:0]  width_reg, width_next;
    logic [HEIGHT_BITS-1:0] height_reg, height_next;
    logic                   cfg_wr;
    reg_idx_t               reg_idx;
    cfg_t                   cfg;
    logic                   nb_valid;
    logic                   nb_ready;
    nbhd_t                  nb;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_WIDTH:  width_next  = pwdata[WIDTH_BITS-1:0];
                REG_HEIGHT: height_next = pwdata[HEIGHT_BITS-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = DATA_BITS'(width_reg);
            REG_HEIGHT: prdata = DATA_BITS'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Clamp geometry: zero acts as one, width saturates at the line store depth.
    always_comb
    begin
        priority if (width_reg == '0)
        begin
            cfg.width = WIDTH_BITS'(1);
        end
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            cfg.width = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end
        cfg.height  = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;
        cfg.restart = cfg_wr;
    end

    sgrad_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .flow_u   (flow_u),
        .flow_v   (flow_v),
        .nb_valid (nb_valid),
        .nb       (nb),
        .nb_ready (nb_ready)
    );

    sgrad_sobel u_sobel (
        .clk       (clk),
        .rst_n     (rst_n),
        .nb_valid  (nb_valid),
        .nb        (nb),
        .nb_ready  (nb_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grad_ux   (grad_ux),
        .grad_uy   (grad_uy),
        .grad_vx   (grad_vx),
        .grad_vy   (grad_vy),
        .frame_end (frame_end)
    );

endmodule
